[hw/rtl/ats_pkg.sv]
// shared types, constants and helpers for the affine transform stack
// no dependencies; imported by every module of the block
`default_nettype none

package ats_pkg;

   localparam int COEF_W          = 32;
   localparam int NUM_COEF        = 6;
   localparam int PROD_W          = 2 * COEF_W;
   localparam int STACK_DEPTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int DEPTH_OUT_W     = 6;
   localparam int STATUS_W        = 2;
   localparam int OPCODE_W        = 2;

   localparam int REQ_DATA_W = NUM_COEF * COEF_W;
   localparam int RSP_BITS   = NUM_COEF * COEF_W + DEPTH_OUT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BITS;

   typedef logic signed [COEF_W-1:0] coef_type;
   // element 0 is a, then b, c, d, e, f
   typedef coef_type [NUM_COEF-1:0] xform_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CONCAT = 2'd0,
      OP_PUSH   = 2'd1,
      OP_POP    = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_SAT   = 2'd3
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic load;
   } cell_ctl_type;

   typedef struct packed {
      logic done;
      logic sat;
   } mac_stat_type;

   function automatic xform_type ident_xform(input int frac_bits);
      xform_type x;
      x = '0;
      x[0] = coef_type'(1) << frac_bits;
      x[3] = coef_type'(1) << frac_bits;
      return x;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/ats_cell.sv]
// one stack cell: holds one transform, shifts with its neighbours
// depends on ats_pkg
`default_nettype none

module ats_cell #(
   parameter int FRAC_BITS = ats_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ats_pkg::cell_ctl_type ctl,
   input  ats_pkg::xform_type   above,
   input  ats_pkg::xform_type   below,
   input  ats_pkg::xform_type   load_val,
   output ats_pkg::xform_type   q
);
   import ats_pkg::*;

   xform_type q_ff, q_in;

   always_comb begin
      q_in = q_ff;
      if (ctl.load) begin
         q_in = load_val;
      end else if (ctl.push) begin
         q_in = above;
      end else if (ctl.pop) begin
         q_in = below;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= ident_xform(FRAC_BITS);
      end else begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

`default_nettype wire

[hw/rtl/ats_mac.sv]
// concatenate unit: one coefficient per cycle through multiply, sum and
// round/saturate stages; depends on ats_pkg
`default_nettype none

module ats_mac #(
   parameter int FRAC_BITS = ats_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ats_pkg::xform_type    coef,
   input  ats_pkg::xform_type    top,
   output ats_pkg::xform_type    result,
   output ats_pkg::mac_stat_type stat
);
   import ats_pkg::*;

   localparam int SUM_W = PROD_W + 2;
   localparam int RES_W = SUM_W + 1;
   localparam int IDX_W = 3;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_COEF - 1);
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);
   localparam coef_type COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam coef_type COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   logic                     busy_ff, busy_in;
   logic [IDX_W-1:0]         cnt_ff, cnt_in;
   logic                     v1_ff, v2_ff, done_ff, sat_ff, sat_in;
   logic [IDX_W-1:0]         idx1_ff, idx2_ff;
   logic signed [PROD_W-1:0] p1_ff, p2_ff, p1_in, p2_in;
   coef_type                 t1_ff, t2_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [RES_W-1:0]  rnd;
   xform_type                res_ff;

   logic [1:0] row;
   logic       col;
   coef_type   ma, mb, ta, tb, tt, val;
   logic       ovf;

   // coefficient k: row k/2 of the item matrix against column k%2 of the top
   always_comb begin
      row = cnt_ff[2:1];
      col = cnt_ff[0];
      ma  = coef[{row, 1'b0}];
      mb  = coef[{row, 1'b1}];
      ta  = col ? top[1] : top[0];
      tb  = col ? top[3] : top[2];
      tt  = (row == 2'd2) ? (col ? top[5] : top[4]) : '0;
      p1_in = PROD_W'(ma) * PROD_W'(ta);
      p2_in = PROD_W'(mb) * PROD_W'(tb);
   end

   always_comb begin
      sum_in = SUM_W'(p1_ff) + SUM_W'(p2_ff) + HALF;
      rnd    = RES_W'(sum_ff >>> FRAC_BITS) + RES_W'(t2_ff);
      ovf    = !((&rnd[RES_W-1:COEF_W-1]) || !(|rnd[RES_W-1:COEF_W-1]));
      val    = ovf ? (rnd[RES_W-1] ? COEF_MIN : COEF_MAX) : rnd[COEF_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      sat_in  = sat_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sat_in  = 1'b0;
      end else begin
         if (busy_ff) begin
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_ff == LAST_IDX) begin
               busy_in = 1'b0;
            end
         end
         if (v2_ff && ovf) begin
            sat_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
         sat_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         v1_ff   <= busy_ff;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff && (idx2_ff == LAST_IDX);
         sat_ff  <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      t1_ff   <= tt;
      idx1_ff <= cnt_ff;
      sum_ff  <= sum_in;
      t2_ff   <= t1_ff;
      idx2_ff <= idx1_ff;
      if (v2_ff) begin
         res_ff[idx2_ff] <= val;
      end
   end

   assign result    = res_ff;
   assign stat.done = done_ff;
   assign stat.sat  = sat_ff;

endmodule

`default_nettype wire

[hw/rtl/affine_transform_stack.sv]
// top level of the affine transform stack: control, depth count, cell row
// depends on ats_pkg, ats_cell, ats_mac
//
// channel | dir | handshake              | payload
// req     | in  | req_tvalid/req_tready  | tdata coef_a..coef_f, tuser opcode
// rsp     | out | rsp_tvalid/rsp_tready  | tdata top_a..top_f, depth; tuser status
//
// push, pop and the unused opcode go from idle straight to the result state;
// concatenate sends the six coefficients one a cycle through the shared
// multiply, sum and round stages.
// the stack is a row of cells with the top in cell 0; push and pop shift the
// whole row at once, so the depth never adds to the time an item takes.
// reset leaves depth one with the identity on top; no clearing pass.
// a stalled result holds in the output register; the next item is still
// taken and worked, then waits until that register frees.
`default_nettype none

module affine_transform_stack #(
   parameter int STACK_DEPTH = ats_pkg::STACK_DEPTH_DEF,
   parameter int FRAC_BITS   = ats_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // coef_a [31:0], coef_b, coef_c, coef_d, coef_e, coef_f [191:160]
   input  logic [ats_pkg::REQ_DATA_W-1:0] req_tdata,
   // opcode [1:0]
   input  logic [ats_pkg::OPCODE_W-1:0]   req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // top_a [31:0], top_b, top_c, top_d, top_e, top_f [191:160],
   // depth [197:192], zero fill [199:198]
   output logic [ats_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status [1:0]
   output logic [ats_pkg::STATUS_W-1:0]   rsp_tuser
);
   import ats_pkg::*;

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
   localparam logic [DEPTH_W-1:0] DEPTH_ONE  = DEPTH_W'(1);
   localparam logic [DEPTH_OUT_W-1:0] DEPTH_OUT_FULL = DEPTH_OUT_W'(STACK_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CALC = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [DEPTH_W-1:0]      depth_ff, depth_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic                    start_ff, start_in;
   xform_type               coef_ff, coef_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   xform_type               rsp_top_ff;
   logic [DEPTH_OUT_W-1:0]  rsp_depth_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;

   logic                    accept, rsp_load;
   logic                    stk_push, stk_pop, cell_load;
   logic [OPCODE_W-1:0]     op;
   xform_type               req_coef, mac_res;
   mac_stat_type            mac_st;
   logic [DEPTH_W+DEPTH_OUT_W-1:0] depth_ext;

   xform_type               stack_q  [STACK_DEPTH];
   cell_ctl_type            cell_ctl [STACK_DEPTH];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign op         = req_tuser;
   assign req_coef   = req_tdata;

   assign stk_push  = accept && (op == OP_PUSH) && (depth_ff != DEPTH_FULL);
   assign stk_pop   = accept && (op == OP_POP) && (depth_ff != DEPTH_ONE);
   assign cell_load = (state_ff == S_CALC) && mac_st.done;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in  = state_ff;
      depth_in  = depth_ff;
      status_in = status_ff;
      start_in  = 1'b0;
      coef_in   = coef_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               coef_in   = req_coef;
               status_in = STAT_OK;
               state_in  = S_DONE;
               case (op)
                  OP_CONCAT: begin
                     start_in = 1'b1;
                     state_in = S_CALC;
                  end
                  OP_PUSH: begin
                     if (depth_ff == DEPTH_FULL) begin
                        status_in = STAT_FULL;
                     end else begin
                        depth_in = depth_ff + DEPTH_ONE;
                     end
                  end
                  OP_POP: begin
                     if (depth_ff == DEPTH_ONE) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        depth_in = depth_ff - DEPTH_ONE;
                     end
                  end
                  default: begin
                     status_in = STAT_OK;
                  end
               endcase
            end
         end
         S_CALC: begin
            if (mac_st.done) begin
               status_in = mac_st.sat ? STAT_SAT : STAT_OK;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign depth_ext = {{DEPTH_OUT_W{1'b0}}, depth_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= DEPTH_ONE;
         status_ff    <= STAT_OK;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         status_ff    <= status_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
      if (rsp_load) begin
         rsp_top_ff    <= stack_q[0];
         rsp_depth_ff  <= depth_ext[DEPTH_OUT_W-1:0];
         rsp_status_ff <= status_ff;
      end
   end

   ats_mac #(
      .FRAC_BITS(FRAC_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .coef  (coef_ff),
      .top   (stack_q[0]),
      .result(mac_res),
      .stat  (mac_st)
   );

   // cell 0 is the top; push moves every entry one cell down, pop one up
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      xform_type above_q, below_q;

      assign cell_ctl[i] = '{push: stk_push, pop: stk_pop,
                             load: (i == 0) ? cell_load : 1'b0};

      if (i == 0) begin : g_first
         assign above_q = stack_q[i];
      end else begin : g_next
         assign above_q = stack_q[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_last
         assign below_q = stack_q[i];
      end else begin : g_prev
         assign below_q = stack_q[i+1];
      end

      ats_cell #(
         .FRAC_BITS(FRAC_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (cell_ctl[i]),
         .above   (above_q),
         .below   (below_q),
         .load_val(mac_res),
         .q       (stack_q[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_depth_ff, rsp_top_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_depth_range : assert property (@(posedge clock) disable iff (reset)
      (depth_ff != '0) && (depth_ff <= DEPTH_FULL))
      else $error("stack depth out of range");

   a_done_in_calc : assert property (@(posedge clock) disable iff (reset)
      mac_st.done |-> (state_ff == S_CALC))
      else $error("concatenate finished outside of calc state");

   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      stk_push |=> (depth_ff == DEPTH_W'($past(depth_ff) + DEPTH_ONE)))
      else $error("push did not grow the stack");

   a_full_depth : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STAT_FULL)) |->
         (rsp_depth_ff == DEPTH_OUT_FULL))
      else $error("full status with stack not full");

   a_busy_stall : assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("item taken while another is in work");

endmodule

`default_nettype wire

[bench/affine_transform_stack_test.sv]
// testbench for affine_transform_stack: directed table, then random stack sequences
// checked item by item against a predictor of the stack; depends on ats_pkg and the rtl
`timescale 1ns / 1ps

module affine_transform_stack_test;
   import ats_pkg::*;

   localparam int FRAC         = FRAC_BITS_DEF;
   localparam int LEVELS       = STACK_DEPTH_DEF;
   localparam int RANDOM_ITEMS = 420;
   localparam int QUIET_TAIL   = 60;
   localparam int HOLD_AT      = 200;
   localparam int HOLD_CYCLES  = 80;
   localparam int TAIL_CYCLES  = 40;

   // opcode the block leaves unused
   localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

   localparam coef_type ONE  = 32'sd1 <<< FRAC;
   localparam coef_type CMAX = 32'sh7fffffff;
   localparam coef_type CMIN = 32'sh80000000;

   typedef struct {
      xform_type                top;
      logic [DEPTH_OUT_W-1:0]   depth;
      status_type               status;
   } top_report_type;

   typedef struct {
      logic [OPCODE_W-1:0] op;
      xform_type           coefs;
      bit                  typed;
      top_report_type      want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // coef_a [31:0], coef_b, coef_c, coef_d, coef_e, coef_f [191:160]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // opcode [1:0]
   logic [OPCODE_W-1:0]   req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // top_a [31:0] .. top_f [191:160], depth [197:192], zero fill [199:198]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // status [1:0]
   logic [STATUS_W-1:0]   rsp_tuser;

   xform_type      stack_mirror [LEVELS];
   int             mirror_level;
   top_report_type pending_tops [$];
   stim_row_type   rows [$];
   int             accepted_count = 0;
   int             random_count = 0;
   int             mismatch_count = 0;
   bit             idling = 1'b0;
   bit             held_off = 1'b0;

   affine_transform_stack i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic xform_type make_xform(input coef_type a, b, c, d, e, f);
      xform_type x;
      x[0] = a;
      x[1] = b;
      x[2] = c;
      x[3] = d;
      x[4] = e;
      x[5] = f;
      return x;
   endfunction

   // (m0*t0 + m1*t1) / 2^F + tr, rounded half up, clipped to 32 bits
   function automatic coef_type blend(input coef_type m0, t0, m1, t1, tr, inout bit clipped);
      logic signed [79:0] x0, y0, x1, y1, xt, acc;
      x0 = m0;
      y0 = t0;
      x1 = m1;
      y1 = t1;
      xt = tr;
      acc = x0 * y0 + x1 * y1 + (xt <<< FRAC) + (80'sd1 <<< (FRAC - 1));
      acc = acc >>> FRAC;
      if (acc > 80'sd2147483647) begin
         clipped = 1'b1;
         return CMAX;
      end
      if (acc < -80'sd2147483648) begin
         clipped = 1'b1;
         return CMIN;
      end
      return coef_type'(acc[31:0]);
   endfunction

   function automatic top_report_type advance_stack(input logic [OPCODE_W-1:0] op,
                                                    input xform_type m);
      top_report_type rep;
      xform_type      t;
      xform_type      n;
      bit             clipped;
      rep.status = STAT_OK;
      clipped = 1'b0;
      t = stack_mirror[mirror_level-1];
      case (op)
         OP_CONCAT: begin
            n[0] = blend(m[0], t[0], m[1], t[2], '0, clipped);
            n[1] = blend(m[0], t[1], m[1], t[3], '0, clipped);
            n[2] = blend(m[2], t[0], m[3], t[2], '0, clipped);
            n[3] = blend(m[2], t[1], m[3], t[3], '0, clipped);
            n[4] = blend(m[4], t[0], m[5], t[2], t[4], clipped);
            n[5] = blend(m[4], t[1], m[5], t[3], t[5], clipped);
            stack_mirror[mirror_level-1] = n;
            if (clipped) begin
               rep.status = STAT_SAT;
            end
         end
         OP_PUSH: begin
            if (mirror_level >= LEVELS) begin
               rep.status = STAT_FULL;
            end else begin
               stack_mirror[mirror_level] = t;
               mirror_level++;
            end
         end
         OP_POP: begin
            if (mirror_level <= 1) begin
               rep.status = STAT_EMPTY;
            end else begin
               mirror_level--;
            end
         end
         default: begin
         end
      endcase
      rep.top = stack_mirror[mirror_level-1];
      rep.depth = DEPTH_OUT_W'(mirror_level);
      return rep;
   endfunction

   function automatic coef_type pick_coef();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return coef_type'($urandom_range(0, ONE <<< 2)) - (ONE <<< 1);
         6, 7: return coef_type'($urandom);
         8: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return ONE;
               2: return -ONE;
               3: return CMAX;
               default: return CMIN;
            endcase
         end
         default: return coef_type'($urandom_range(0, 65535)) - 32'sd32768;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
   endtask

   task automatic add_row(input stim_row_type row);
      rows.insert(rows.size(), row);
   endtask

   // called at a falling edge; returns at a falling edge after the item is taken
   task automatic offer_item(input logic [OPCODE_W-1:0] op, input xform_type m,
                             input bit typed, input top_report_type want);
      top_report_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= m;
      do @(posedge clock); while (!req_tready);
      predicted = advance_stack(op, m);
      if (typed) begin
         pending_tops.insert(pending_tops.size(), want);
      end else begin
         pending_tops.insert(pending_tops.size(), predicted);
      end
      accepted_count++;
      @(negedge clock);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   task automatic random_item(input logic [OPCODE_W-1:0] op);
      top_report_type unused;
      xform_type      m;
      for (int k = 0; k < NUM_COEF; k++) begin
         m[k] = pick_coef();
      end
      if (random_count >= RANDOM_ITEMS - QUIET_TAIL) begin
         idling = 1'b0;
      end
      offer_item(op, m, 1'b0, unused);
      if (op != OP_SPARE) begin
         random_count++;
      end
   endtask

   // result side: random stalls, and one long hold-off so the block backs up
   initial begin : result_side
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!held_off && accepted_count >= HOLD_AT) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (idling && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      top_report_type want;
      xform_type      got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_tops.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_tdata[31:0], '0);
         end else begin
            want = pending_tops.pop_front();
            got = rsp_tdata[REQ_DATA_W-1:0];
            for (int k = 0; k < NUM_COEF; k++) begin
               if (got[k] !== want.top[k]) begin
                  report_mismatch($sformatf("top coef %0d", k), got[k], want.top[k]);
               end
            end
            if (rsp_tdata[REQ_DATA_W +: DEPTH_OUT_W] !== want.depth) begin
               report_mismatch("depth", 32'(rsp_tdata[REQ_DATA_W +: DEPTH_OUT_W]),
                               32'(want.depth));
            end
            if (rsp_tuser !== want.status) begin
               report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
            end
         end
      end
   end

   initial begin : stimulus
      xform_type    ident;
      xform_type    shifted;
      int           seg;

      ident = make_xform(ONE, '0, '0, ONE, '0, '0);
      shifted = make_xform(ONE, '0, '0, ONE, ONE * 3, -(ONE * 2));
      foreach (stack_mirror[k]) begin
         stack_mirror[k] = '0;
      end
      stack_mirror[0] = ident;
      mirror_level = 1;

      // after reset, the empty pop, simple shifts: typed; the rest from the predictor
      add_row('{OP_SPARE, '0, 1'b1, '{ident, 6'd1, STAT_OK}});
      add_row('{OP_POP, '0, 1'b1, '{ident, 6'd1, STAT_EMPTY}});
      add_row('{OP_CONCAT, ident, 1'b1, '{ident, 6'd1, STAT_OK}});
      add_row('{OP_CONCAT, shifted, 1'b1, '{shifted, 6'd1, STAT_OK}});
      add_row('{OP_PUSH, '0, 1'b1, '{shifted, 6'd2, STAT_OK}});
      add_row('{OP_CONCAT, make_xform(ONE * 2, '0, '0, ONE * 2, '0, '0), 1'b1,
                '{make_xform(ONE * 2, '0, '0, ONE * 2, ONE * 3, -(ONE * 2)),
                  6'd2, STAT_OK}});
      add_row('{OP_CONCAT, make_xform(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1'b0,
                '{'0, '0, STAT_OK}});
      add_row('{OP_CONCAT, make_xform(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1'b0,
                '{'0, '0, STAT_OK}});
      add_row('{OP_POP, '0, 1'b1, '{shifted, 6'd1, STAT_OK}});
      add_row('{OP_POP, '1, 1'b1, '{shifted, 6'd1, STAT_EMPTY}});
      add_row('{OP_CONCAT, make_xform('0, ONE, -ONE, '0, ONE * 5, ONE * 7), 1'b0,
                '{'0, '0, STAT_OK}});
      // exact halves, rounding up on both signs
      add_row('{OP_CONCAT, make_xform(32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1),
                1'b0, '{'0, '0, STAT_OK}});
      add_row('{OP_CONCAT, make_xform(ONE >>> 1, -(ONE >>> 1), ONE, ONE, -32'sd32768,
                                      32'sd32768), 1'b0, '{'0, '0, STAT_OK}});
      add_row('{OP_PUSH, '1, 1'b0, '{'0, '0, STAT_OK}});
      add_row('{OP_CONCAT, '0, 1'b0, '{'0, '0, STAT_OK}});
      add_row('{OP_CONCAT, make_xform(CMAX, CMIN, CMIN, CMAX, CMAX, CMIN), 1'b0,
                '{'0, '0, STAT_OK}});
      add_row('{OP_SPARE, '1, 1'b0, '{'0, '0, STAT_OK}});
      add_row('{OP_POP, '0, 1'b0, '{'0, '0, STAT_OK}});
      add_row('{OP_CONCAT, make_xform(ONE, ONE, -ONE, ONE, CMAX, CMIN), 1'b0,
                '{'0, '0, STAT_OK}});

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      idling = 1'b1;
      foreach (rows[r]) begin
         offer_item(rows[r].op, rows[r].coefs, rows[r].typed, rows[r].want);
      end

      while (random_count < RANDOM_ITEMS) begin
         idling = (random_count < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         seg = $urandom_range(0, 9);
         if (seg <= 2) begin
            // climb to a full stack, then push against it
            while (mirror_level < LEVELS) begin
               if ($urandom_range(0, 2) == 0) begin
                  random_item(OP_CONCAT);
               end else begin
                  random_item(OP_PUSH);
               end
            end
            repeat ($urandom_range(1, 2)) random_item(OP_PUSH);
         end else if (seg <= 4) begin
            // unwind to the bottom entry, then pop against it
            while (mirror_level > 1) begin
               if ($urandom_range(0, 2) == 0) begin
                  random_item(OP_CONCAT);
               end else begin
                  random_item(OP_POP);
               end
            end
            repeat ($urandom_range(1, 2)) random_item(OP_POP);
         end else begin
            repeat ($urandom_range(8, 20)) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: random_item(OP_CONCAT);
                  5, 6: random_item(OP_PUSH);
                  7, 8: random_item(OP_POP);
                  default: random_item(OP_SPARE);
               endcase
            end
         end
      end

      idling = 1'b0;
      req_tvalid <= 1'b0;
      while (pending_tops.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/ats_pkg.sv
hw/rtl/ats_cell.sv
hw/rtl/ats_mac.sv
hw/rtl/affine_transform_stack.sv
bench/affine_transform_stack_test.sv
